// File: sv/segint_pkg.sv
// Shared constants and types of the segment intersection core.
`default_nettype none
package segint_pkg;
    localparam int COORD_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_COORDS      = 8;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage
`default_nettype wire

// File: sv/segint_front.sv
// Front end: registers segment pairs, computes orientation classes and the hit flag.
`default_nettype none
module segint_front
    import segint_pkg::*;
#(
    parameter int N = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [N-1:0]   i_pt [NUM_COORDS],
    input  logic                  i_full,
    output logic                  o_push,
    output logic [NUM_COORDS*N:0] o_entry
);
    localparam int MW = 2 * N + 2;
    localparam int VW = 2 * N + 3;
    localparam int PP [4] = '{0, 0, 2, 2};
    localparam int QP [4] = '{1, 1, 3, 3};
    localparam int RP [4] = '{2, 3, 0, 1};

    typedef enum logic [1:0] {
        OR_COL = 2'd0,
        OR_CW  = 2'd1,
        OR_CCW = 2'd2
    } t_orient;

    logic                r_v0, r_v1, r_v2;
    logic signed [N-1:0] r_p0 [NUM_COORDS];
    logic signed [N-1:0] r_p1 [NUM_COORDS];
    logic signed [N-1:0] r_p2 [NUM_COORDS];
    logic signed [MW-1:0] r_m1 [4];
    logic signed [MW-1:0] r_m2 [4];
    logic signed [MW-1:0] n_m1 [4];
    logic signed [MW-1:0] n_m2 [4];
    logic                r_hit, n_hit;
    logic signed [VW-1:0] v [4];
    t_orient             ocl [4];
    logic                w_in [4];
    logic                f_en;

    function automatic logic inbox(input logic signed [N-1:0] px, input logic signed [N-1:0] py,
                                   input logic signed [N-1:0] qx, input logic signed [N-1:0] qy,
                                   input logic signed [N-1:0] rx, input logic signed [N-1:0] ry);
        logic signed [N-1:0] xlo, xhi, ylo, yhi;
        xlo = (px < rx) ? px : rx;
        xhi = (px < rx) ? rx : px;
        ylo = (py < ry) ? py : ry;
        yhi = (py < ry) ? ry : py;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    assign f_en   = ~i_full;
    assign o_push = r_v2 & ~i_full;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_m1[k] = (MW'(r_p0[2*QP[k]+1]) - MW'(r_p0[2*PP[k]+1]))
                    * (MW'(r_p0[2*RP[k]]) - MW'(r_p0[2*QP[k]]));
            n_m2[k] = (MW'(r_p0[2*QP[k]]) - MW'(r_p0[2*PP[k]]))
                    * (MW'(r_p0[2*RP[k]+1]) - MW'(r_p0[2*QP[k]+1]));
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            v[k] = VW'(r_m1[k]) - VW'(r_m2[k]);
            if (v[k] == '0) begin
                ocl[k] = OR_COL;
            end else if (!v[k][VW-1]) begin
                ocl[k] = OR_CW;
            end else begin
                ocl[k] = OR_CCW;
            end
            w_in[k] = (ocl[k] == OR_COL)
                && inbox(r_p1[2*PP[k]], r_p1[2*PP[k]+1], r_p1[2*RP[k]], r_p1[2*RP[k]+1],
                         r_p1[2*QP[k]], r_p1[2*QP[k]+1]);
        end
        n_hit = ((ocl[0] != ocl[1]) && (ocl[2] != ocl[3]))
              || w_in[0] || w_in[1] || w_in[2] || w_in[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (f_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_p0  <= i_pt;
            r_p1  <= r_p0;
            r_p2  <= r_p1;
            r_m1  <= n_m1;
            r_m2  <= n_m2;
            r_hit <= n_hit;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            o_entry[k*N +: N] = r_p2[k];
        end
        o_entry[NUM_COORDS*N] = r_hit;
    end
endmodule
`default_nettype wire

// File: sv/segint_fifo.sv
// Short queue that decouples the front end from the point pipeline.
`default_nettype none
module segint_fifo
    import segint_pkg::*;
#(
    parameter int W     = 8 * COORD_BITS_DEF + 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_stat      o_stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] incr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= incr(r_wp);
            end
            if (i_pop) begin
                r_rp <= incr(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

// File: sv/segint_div.sv
// Pipelined restoring divider giving one quotient bit per stage.
`default_nettype none
module segint_div #(
    parameter int QB = 16,
    parameter int NW = 52,
    parameter int DW = 35
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);
    logic [NW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic [NW-1:0] rem_in, sh;
            logic [DW-1:0] den_in;
            logic [QB-1:0] q_in;
            logic          ge;
            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
                assign q_in   = r_q[k-1];
            end
            assign sh = NW'(den_in) << (QB - 1 - k);
            assign ge = (rem_in >= sh);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? (rem_in - sh) : rem_in;
                    r_den[k] <= den_in;
                    r_q[k]   <= {q_in[QB-2:0], ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_q[QB-1];
endmodule
`default_nettype wire

// File: sv/segint_back.sv
// Back end: line equations, numerators, determinant, division and the result register.
`default_nettype none
module segint_back
    import segint_pkg::*;
#(
    parameter int N = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [NUM_COORDS*N:0] i_entry,
    input  logic                  i_stall,
    output logic                  o_take,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_collinear_overlap,
    output logic signed [N-1:0]   o_cross_x,
    output logic signed [N-1:0]   o_cross_y
);
    localparam int DW = N + 1;
    localparam int MW = 2 * N + 2;
    localparam int VW = 2 * N + 3;
    localparam int LW = N + 1;
    localparam int PW = 2 * N + 3;
    localparam int NW = 3 * N + 4;

    logic en;
    logic [5:0] r_v;
    logic [5:0] r_h;

    logic signed [N-1:0] r_c [NUM_COORDS];
    logic signed [DW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [MW-1:0] r1_p1, r1_p2, r1_p3, r1_p4, r1_d1, r1_d2;
    logic signed [DW-1:0] r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [MW-1:0] r2_c1, r2_c2;
    logic signed [VW-1:0] r2_det, r3_det, r4_det;
    logic signed [PW-1:0] r3_xh1, r3_xl1, r3_xh2, r3_xl2;
    logic signed [PW-1:0] r3_yh1, r3_yl1, r3_yh2, r3_yl2;
    logic signed [NW-1:0] r4_nx, r4_ny, n_nx, n_ny;
    logic [NW-1:0] r5_mx, r5_my;
    logic [VW-1:0] r5_md;
    logic r5_sx, r5_sy, r5_z;
    logic [N-1:0] q_x, q_y;
    logic [N-1:0] r_sv, r_sh, r_sz, r_ssx, r_ssy;
    logic signed [DW-1:0] s1_a1, s1_b1, s1_a2, s1_b2;

    assign en     = ~(o_valid & i_stall);
    assign o_take = en;

    assign s1_a1 = DW'(r_c[3]) - DW'(r_c[1]);
    assign s1_b1 = DW'(r_c[0]) - DW'(r_c[2]);
    assign s1_a2 = DW'(r_c[7]) - DW'(r_c[5]);
    assign s1_b2 = DW'(r_c[4]) - DW'(r_c[6]);

    always_comb begin
        n_nx = ((NW'(r3_xh1) - NW'(r3_xh2)) <<< LW) + NW'(r3_xl1) - NW'(r3_xl2);
        n_ny = ((NW'(r3_yh1) - NW'(r3_yh2)) <<< LW) + NW'(r3_yl1) - NW'(r3_yl2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_sv    <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[4:0], i_valid};
            r_sv    <= {r_sv[N-2:0], r_v[5]};
            o_valid <= r_sv[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_COORDS; k++) begin
                r_c[k] <= i_entry[k*N +: N];
            end
            r_h   <= {r_h[4:0], i_entry[NUM_COORDS*N]};
            r1_a1 <= s1_a1;
            r1_b1 <= s1_b1;
            r1_a2 <= s1_a2;
            r1_b2 <= s1_b2;
            r1_p1 <= MW'(s1_a1) * MW'(r_c[0]);
            r1_p2 <= MW'(s1_b1) * MW'(r_c[1]);
            r1_p3 <= MW'(s1_a2) * MW'(r_c[4]);
            r1_p4 <= MW'(s1_b2) * MW'(r_c[5]);
            r1_d1 <= MW'(s1_a1) * MW'(s1_b2);
            r1_d2 <= MW'(s1_a2) * MW'(s1_b1);
            r2_a1  <= r1_a1;
            r2_b1  <= r1_b1;
            r2_a2  <= r1_a2;
            r2_b2  <= r1_b2;
            r2_c1  <= r1_p1 + r1_p2;
            r2_c2  <= r1_p3 + r1_p4;
            r2_det <= VW'(r1_d1) - VW'(r1_d2);
            r3_xh1 <= PW'(r2_b2) * PW'($signed(r2_c1[MW-1:LW]));
            r3_xl1 <= PW'(r2_b2) * PW'($signed({1'b0, r2_c1[LW-1:0]}));
            r3_xh2 <= PW'(r2_b1) * PW'($signed(r2_c2[MW-1:LW]));
            r3_xl2 <= PW'(r2_b1) * PW'($signed({1'b0, r2_c2[LW-1:0]}));
            r3_yh1 <= PW'(r2_a1) * PW'($signed(r2_c2[MW-1:LW]));
            r3_yl1 <= PW'(r2_a1) * PW'($signed({1'b0, r2_c2[LW-1:0]}));
            r3_yh2 <= PW'(r2_a2) * PW'($signed(r2_c1[MW-1:LW]));
            r3_yl2 <= PW'(r2_a2) * PW'($signed({1'b0, r2_c1[LW-1:0]}));
            r3_det <= r2_det;
            r4_nx  <= n_nx;
            r4_ny  <= n_ny;
            r4_det <= r3_det;
            r5_mx  <= r4_nx[NW-1] ? NW'(-r4_nx) : NW'(r4_nx);
            r5_my  <= r4_ny[NW-1] ? NW'(-r4_ny) : NW'(r4_ny);
            r5_md  <= r4_det[VW-1] ? VW'(-r4_det) : VW'(r4_det);
            r5_sx  <= r4_nx[NW-1] ^ r4_det[VW-1];
            r5_sy  <= r4_ny[NW-1] ^ r4_det[VW-1];
            r5_z   <= (r4_det == '0);
            r_sh   <= {r_sh[N-2:0], r_h[5]};
            r_sz   <= {r_sz[N-2:0], r5_z};
            r_ssx  <= {r_ssx[N-2:0], r5_sx};
            r_ssy  <= {r_ssy[N-2:0], r5_sy};
            o_hit  <= r_sh[N-1];
            o_collinear_overlap <= r_sh[N-1] & r_sz[N-1];
            if (!r_sh[N-1]) begin
                o_cross_x <= '0;
                o_cross_y <= '0;
            end else if (r_sz[N-1]) begin
                o_cross_x <= {1'b0, {(N-1){1'b1}}};
                o_cross_y <= {1'b0, {(N-1){1'b1}}};
            end else begin
                o_cross_x <= r_ssx[N-1] ? -q_x : q_x;
                o_cross_y <= r_ssy[N-1] ? -q_y : q_y;
            end
        end
    end

    segint_div #(.QB(N), .NW(NW), .DW(VW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_mx),
        .i_den (r5_md),
        .o_quo (q_x)
    );

    segint_div #(.QB(N), .NW(NW), .DW(VW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_my),
        .i_den (r5_md),
        .o_quo (q_y)
    );
endmodule
`default_nettype wire

// File: sv/segment_intersection_point_core.sv
// Top level of the segment intersection core: front end, queue and point pipeline.
// Usage: the input channel carries two segments AB and CD as signed endpoints; a transfer
// takes place on a rising edge with i_valid high and o_stall low. The output channel gives
// one result per input transfer: o_hit, o_collinear_overlap and the crossing point, taken
// on an edge with o_valid high and i_stall low.
// Throughput is one segment pair per cycle while neither o_stall nor i_stall is raised. From
// input transfer to o_valid a pair passes three front stages, a queue slot, six stages for the line
// equations and numerators, one divider stage per quotient bit and the result register.
// The quotient is produced by two restoring dividers, one bit per pipeline stage.
// The front end stops taking transfers only when the queue is full; the back pipeline
// freezes as a whole while a result is held under i_stall, and the queue then fills.
// Reset clears all valid flags and the queue pointers; no result is pending afterwards.
`default_nettype none
module segment_intersection_point_core
    import segint_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_seg1_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg1_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg1_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg1_end_y,
    input  logic signed [COORD_BITS-1:0] i_seg2_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg2_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg2_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg2_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic                         o_collinear_overlap,
    output logic signed [COORD_BITS-1:0] o_cross_x,
    output logic signed [COORD_BITS-1:0] o_cross_y
);
    localparam int EW = NUM_COORDS * COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] pt [NUM_COORDS];
    logic          push, pop, take;
    logic [EW-1:0] f_entry, q_entry;
    t_q_stat       qs;

    assign pt[0] = i_seg1_start_x;
    assign pt[1] = i_seg1_start_y;
    assign pt[2] = i_seg1_end_x;
    assign pt[3] = i_seg1_end_y;
    assign pt[4] = i_seg2_start_x;
    assign pt[5] = i_seg2_start_y;
    assign pt[6] = i_seg2_end_x;
    assign pt[7] = i_seg2_end_y;

    assign o_stall = qs.full;
    assign pop     = take & ~qs.empty;

    segint_front #(.N(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pt    (pt),
        .i_full  (qs.full),
        .o_push  (push),
        .o_entry (f_entry)
    );

    segint_fifo #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_entry),
        .i_pop   (pop),
        .o_data  (q_entry),
        .o_stat  (qs)
    );

    segint_back #(.N(COORD_BITS)) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (pop),
        .i_entry             (q_entry),
        .i_stall             (i_stall),
        .o_take              (take),
        .o_valid             (o_valid),
        .o_hit               (o_hit),
        .o_collinear_overlap (o_collinear_overlap),
        .o_cross_x           (o_cross_x),
        .o_cross_y           (o_cross_y)
    );

    a_ovl_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_collinear_overlap |-> o_hit)
        else $error("Overlap flag raised without a hit.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_cross_x == '0) && (o_cross_y == '0))
        else $error("Non-zero point on a miss.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qs.full |-> !push)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qs.empty |-> !pop)
        else $error("Queue read while empty.");
endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench of the segment intersection core with a built-in point predictor.
module testbench
    import segint_pkg::*;
();

    localparam int CB = COORD_BITS_DEF;

    typedef struct {
        logic signed [CB-1:0] c [8];
    } t_pair;

    typedef struct {
        logic                 hit;
        logic                 overlap;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [CB-1:0] drv [8];
    logic o_stall, o_valid, o_hit, o_collinear_overlap;
    logic signed [CB-1:0] o_cross_x, o_cross_y;

    t_pair  pending_pairs [$];
    t_point expected_points [$];
    int     mismatches = 0;
    bit     stim_done = 1'b0;
    bit     hold_off = 1'b0;
    bit     in_taken = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     stall_phase = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < 8; i++) drv[i] = '0;
    end

    segment_intersection_point_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_seg1_start_x(drv[0]), .i_seg1_start_y(drv[1]),
        .i_seg1_end_x(drv[2]), .i_seg1_end_y(drv[3]),
        .i_seg2_start_x(drv[4]), .i_seg2_start_y(drv[5]),
        .i_seg2_end_x(drv[6]), .i_seg2_end_y(drv[7]),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit),
        .o_collinear_overlap(o_collinear_overlap),
        .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    function automatic int orientation(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        if (v == 0) return 0;
        return (v > 0) ? 1 : 2;
    endfunction

    function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
        return qx >= ((px < rx) ? px : rx) && qx <= ((px < rx) ? rx : px)
            && qy >= ((py < ry) ? py : ry) && qy <= ((py < ry) ? ry : py);
    endfunction

    function automatic t_point crossing_point(t_pair p);
        t_point r;
        longint ax, ay, bx, by, cx, cy, dx, dy, a1, b1, a2, b2, c1, c2, det;
        logic signed [127:0] nx, ny, qx, qy;
        int o1, o2, o3, o4;
        ax = p.c[0]; ay = p.c[1]; bx = p.c[2]; by = p.c[3];
        cx = p.c[4]; cy = p.c[5]; dx = p.c[6]; dy = p.c[7];
        o1 = orientation(ax, ay, bx, by, cx, cy);
        o2 = orientation(ax, ay, bx, by, dx, dy);
        o3 = orientation(cx, cy, dx, dy, ax, ay);
        o4 = orientation(cx, cy, dx, dy, bx, by);
        r.hit = (o1 != o2 && o3 != o4)
            || (o1 == 0 && in_box(ax, ay, cx, cy, bx, by))
            || (o2 == 0 && in_box(ax, ay, dx, dy, bx, by))
            || (o3 == 0 && in_box(cx, cy, ax, ay, dx, dy))
            || (o4 == 0 && in_box(cx, cy, bx, by, dx, dy));
        r.overlap = 1'b0; r.x = '0; r.y = '0;
        if (r.hit) begin
            a1 = by - ay; b1 = ax - bx; a2 = dy - cy; b2 = cx - dx;
            c1 = a1 * ax + b1 * ay;
            c2 = a2 * cx + b2 * cy;
            det = a1 * b2 - a2 * b1;
            if (det == 0) begin
                r.overlap = 1'b1;
                r.x = {1'b0, {(CB-1){1'b1}}};
                r.y = {1'b0, {(CB-1){1'b1}}};
            end else begin
                nx = 128'(signed'(b2)) * 128'(signed'(c1)) - 128'(signed'(b1)) * 128'(signed'(c2));
                ny = 128'(signed'(a1)) * 128'(signed'(c2)) - 128'(signed'(a2)) * 128'(signed'(c1));
                qx = nx / 128'(signed'(det));
                qy = ny / 128'(signed'(det));
                r.x = qx[CB-1:0];
                r.y = qy[CB-1:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic logic signed [CB-1:0] any_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom_range(0, 40)) - CB'(20);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int s, k;
        logic signed [CB-1:0] t;
        s = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++) p.c[i] = any_coord();
        if (s == 1) begin
            // Small segments with every coordinate in -100 to 100.
            for (int i = 0; i < 8; i++) p.c[i] = CB'($urandom_range(0, 200)) - CB'(100);
        end else if (s == 2) begin
            // Collinear segments on a common line.
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 4; i++) begin
                t = CB'($urandom_range(0, 2000)) - CB'(1000);
                p.c[2*i] = t;
                p.c[2*i+1] = CB'(t * k);
            end
        end else if (s == 3) begin
            // Shared endpoint.
            p.c[4] = p.c[$urandom_range(0, 1) * 2];
            p.c[5] = p.c[4] == p.c[0] ? p.c[1] : p.c[3];
        end
        return p;
    endfunction

    function automatic t_pair make_pair(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
        t_pair p;
        p.c[0] = CB'(ax); p.c[1] = CB'(ay); p.c[2] = CB'(bx); p.c[3] = CB'(by);
        p.c[4] = CB'(cx); p.c[5] = CB'(cy); p.c[6] = CB'(dx); p.c[7] = CB'(dy);
        return p;
    endfunction

    initial begin
        t_pair p;
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 20, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 11, 0, 20, 0));
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 3, 3, 3, 3));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, -5, 5, 0));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, -32768, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          -32768, -32768, 32767, 32766));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 7, 3, 1, 2, 5, -4));
        for (int n = 0; n < 1600; n++) begin
            p = random_pair();
            pending_pairs.push_back(p);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (pending_pairs.size() != 0 && !hold_off && gap_left == 0) begin
                    p_drive();
                end else begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    if (hold_off && expected_points.size() == 0 && !o_valid)
                        hold_off <= 1'b0;
                end
            end
            stall_phase <= stall_phase + 1;
            i_stall <= (stall_phase % 300 < 100) ? 1'b0
                : ((stall_phase % 7 < 3) || ($urandom_range(0, 5) == 0));
        end
    end

    task automatic p_drive();
        t_pair p;
        p = pending_pairs.pop_front();
        for (int i = 0; i < 8; i++) drv[i] <= p.c[i];
        i_valid <= 1'b1;
        if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end else begin
            burst_left <= burst_left - 1;
        end
        if (pending_pairs.size() == 800) hold_off <= 1'b1;
        if (pending_pairs.size() == 0) stim_done <= 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_pair  p;
        t_point e;
        if (i_rst_n) begin
            in_taken = i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                for (int i = 0; i < 8; i++) p.c[i] = drv[i];
                expected_points.push_back(crossing_point(p));
            end
            if (o_valid && !i_stall) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    e = expected_points.pop_front();
                    if (o_hit !== e.hit) report_mismatch("hit", o_hit, e.hit);
                    if (o_collinear_overlap !== e.overlap)
                        report_mismatch("collinear_overlap", o_collinear_overlap, e.overlap);
                    if (o_cross_x !== e.x) report_mismatch("cross_x", o_cross_x, e.x);
                    if (o_cross_y !== e.y) report_mismatch("cross_y", o_cross_y, e.y);
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && !i_valid && expected_points.size() == 0);
        repeat (CB + 40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("segment_intersection_point_core verification clean");
        end else begin
            $display("segment_intersection_point_core verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("segment_intersection_point_core verification failed");
        $finish;
    end
endmodule

// File: segment_intersection_point_core.f
sv/segint_pkg.sv
sv/segint_front.sv
sv/segint_fifo.sv
sv/segint_div.sv
sv/segint_back.sv
sv/segment_intersection_point_core.sv
test/testbench.sv
